// ===== sv/control_to_midi_mapper_unit_assert.svh =====
// assertion macros shared by the mapper modules
// expects clk and rst_n in the scope of each use
`ifndef CONTROL_TO_MIDI_MAPPER_UNIT_ASSERT_SVH
`define CONTROL_TO_MIDI_MAPPER_UNIT_ASSERT_SVH

// same-cycle implication
`define CTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ctm_pkg.sv =====
// types and constants of the control-to-midi mapper
// no dependencies
package ctm_pkg;

  typedef enum logic [2:0] {
    OP_POS    = 3'd0,
    OP_BTN    = 3'd1,
    OP_WRMAP  = 3'd2,
    OP_REMOVE = 3'd3,
    OP_NAV    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL1,
    ST_MUL2,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [5:0]         control_id;
    logic signed [23:0] position;
    logic               key_pressed;
    logic               slot_select;
    logic [3:0]         map_channel;
    logic [6:0]         map_number;
    logic               map_relative;
    logic               nav_value;
  } in_item_t;

  typedef struct packed {
    logic       msg_kind;
    logic [3:0] out_channel;
    logic [6:0] out_number;
    logic [6:0] out_value;
  } out_item_t;

  // one table entry per control
  typedef struct packed {
    logic [3:0]  enc_ch;
    logic [6:0]  enc_num;
    logic        enc_rel;
    logic [3:0]  btn_ch;
    logic [6:0]  btn_num;
    logic [23:0] last_pos;
    logic [6:0]  last_val;
    logic [24:0] fofs;
  } ent_t;

  typedef struct packed {
    logic ent_we;
    ent_t ent;
    logic enc_v_we;
    logic enc_v;
    logic btn_v_we;
    logic btn_v;
    logic nav_we;
    logic nav;
  } tbl_wr_t;

  typedef struct packed {
    logic enc_v;
    logic btn_v;
    logic nav;
  } tbl_flags_t;

  localparam logic        REG_SENS   = 1'b0;
  localparam logic        REG_GAIN   = 1'b1;
  localparam logic [15:0] SENS_RESET = 16'd256;
  localparam logic [15:0] GAIN_RESET = 16'd256;
  localparam logic [15:0] SENS_UNITY = 16'd256;
  localparam logic        KIND_CC    = 1'b0;
  localparam logic        KIND_NOTE  = 1'b1;
  localparam logic [6:0]  MIDI_MAX   = 7'd127;
  localparam logic [16:0] SCL_CAP    = 17'h10000;
  localparam logic [8:0]  STEP_CAP   = 9'd256;

endpackage

// ===== sv/ctm_table.sv =====
// per-control table: entry memory plus valid and navigation flags
// depends on ctm_pkg and control_to_midi_mapper_unit_assert.svh
`include "control_to_midi_mapper_unit_assert.svh"

module ctm_table #(
  parameter int NUM_CONTROLS = 64,
  parameter int IDX_W        = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_idx,
  output ctm_pkg::ent_t       rd_ent,
  output ctm_pkg::tbl_flags_t rd_flags,
  input  logic [IDX_W-1:0]    wr_idx,
  input  ctm_pkg::tbl_wr_t    wr
);

  ctm_pkg::ent_t mem [NUM_CONTROLS];
  ctm_pkg::ent_t rd_ent_r;

  logic [NUM_CONTROLS-1:0] enc_v_r;
  logic [NUM_CONTROLS-1:0] btn_v_r;
  logic [NUM_CONTROLS-1:0] nav_r;
  ctm_pkg::tbl_flags_t     flags_r;

  always_ff @(posedge clk) begin
    if (wr.ent_we) begin
      mem[wr_idx] <= wr.ent;
    end
    if (rd_en) begin
      rd_ent_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_v_r <= '0;
      btn_v_r <= '0;
      nav_r   <= '0;
      flags_r <= '0;
    end else begin
      if (wr.enc_v_we) enc_v_r[wr_idx] <= wr.enc_v;
      if (wr.btn_v_we) btn_v_r[wr_idx] <= wr.btn_v;
      if (wr.nav_we)   nav_r[wr_idx]   <= wr.nav;
      if (rd_en) begin
        flags_r.enc_v <= enc_v_r[rd_idx];
        flags_r.btn_v <= btn_v_r[rd_idx];
        flags_r.nav   <= nav_r[rd_idx];
      end
    end
  end

  assign rd_ent   = rd_ent_r;
  assign rd_flags = flags_r;

  `CTM_ASSERT_NOW(a_no_rd_wr_overlap, wr.ent_we, !rd_en, "table read and write overlap")
  `CTM_ASSERT_NOW(a_enc_map_writes_ent, wr.enc_v_we && wr.enc_v, wr.ent_we,
                  "encoder mapping set without entry write")

endmodule

// ===== sv/control_to_midi_mapper_unit.sv =====
// a result passes the read, two multiply and final stages before it reaches the output register
// a new item is taken only in idle, once the last one has run read, two multiply stages and write-back
// the per-control table is one memory read at accept and written in the last stage
// reset: flags cleared at once, registers to 256, no clearing pass over the memory
// depends on ctm_pkg, ctm_table and control_to_midi_mapper_unit_assert.svh
`include "control_to_midi_mapper_unit_assert.svh"

module control_to_midi_mapper_unit #(
  parameter int NUM_CONTROLS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ctm_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ctm_pkg::out_item_t   out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int IDX_W = (NUM_CONTROLS > 1) ? $clog2(NUM_CONTROLS) : 1;

  // configuration registers
  logic [15:0] sens_r;
  logic [15:0] gain_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r <= ctm_pkg::SENS_RESET;
      gain_r <= ctm_pkg::GAIN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        ctm_pkg::REG_SENS: sens_r <= pwdata[15:0];
        ctm_pkg::REG_GAIN: gain_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == ctm_pkg::REG_GAIN) ? {16'd0, gain_r} : {16'd0, sens_r};

  // control
  ctm_pkg::state_t state_r, state_nxt;
  logic            accept;
  logic            slot_free;
  logic            fin_go;
  logic            out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ctm_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign fin_go    = (state_r == ctm_pkg::ST_FIN) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ctm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ctm_pkg::ST_IDLE: if (accept) state_nxt = ctm_pkg::ST_READ;
      ctm_pkg::ST_READ: state_nxt = ctm_pkg::ST_MUL1;
      ctm_pkg::ST_MUL1: state_nxt = ctm_pkg::ST_MUL2;
      ctm_pkg::ST_MUL2: state_nxt = ctm_pkg::ST_FIN;
      ctm_pkg::ST_FIN:  if (slot_free) state_nxt = ctm_pkg::ST_IDLE;
      default:          state_nxt = ctm_pkg::ST_IDLE;
    endcase
  end

  // table
  logic [8:0]          in_id_ext;
  logic [IDX_W-1:0]    rd_idx;
  ctm_pkg::ent_t       rd_ent;
  ctm_pkg::tbl_flags_t flags;
  ctm_pkg::tbl_wr_t    tbl_wr;
  logic [IDX_W-1:0]    idx_r;

  assign in_id_ext = 9'(in_data.control_id);
  assign rd_idx    = in_id_ext[IDX_W-1:0];

  ctm_table #(
    .NUM_CONTROLS(NUM_CONTROLS),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_idx  (rd_idx),
    .rd_ent  (rd_ent),
    .rd_flags(flags),
    .wr_idx  (idx_r),
    .wr      (tbl_wr)
  );

  // captured transaction
  ctm_pkg::in_item_t item_r;
  logic              id_ok_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r  <= in_data;
      idx_r   <= rd_idx;
      id_ok_r <= (in_id_ext < 9'(NUM_CONTROLS));
    end
  end

  // read stage: movement and absolute-mode offset
  logic signed [24:0] pos25;
  logic signed [24:0] lp25;
  logic signed [24:0] fofs25;
  logic signed [24:0] delta;
  logic signed [25:0] adj;
  logic               adj_neg, adj_big;
  logic [24:0]        mag_nxt, ofs_nxt;
  logic [6:0]         absv_nxt;

  logic [24:0] mag_r;
  logic        neg_r;
  logic        dz_r;
  logic [24:0] ofs_r;
  logic [6:0]  absv_r;

  always_comb begin
    pos25   = 25'(item_r.position);
    lp25    = 25'($signed(rd_ent.last_pos));
    fofs25  = $signed(rd_ent.fofs);
    delta   = pos25 - lp25;
    mag_nxt = delta[24] ? (25'd0 - delta) : delta;
    adj     = 26'(pos25) - 26'(fofs25);
    adj_neg = adj[25];
    adj_big = !adj_neg && (adj > 26'sd127);
    if (adj_neg) begin
      ofs_nxt  = pos25;
      absv_nxt = '0;
    end else if (adj_big) begin
      ofs_nxt  = pos25 - 25'sd127;
      absv_nxt = ctm_pkg::MIDI_MAX;
    end else begin
      ofs_nxt  = fofs25;
      absv_nxt = adj[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ctm_pkg::ST_READ) begin
      mag_r  <= mag_nxt;
      neg_r  <= delta[24];
      dz_r   <= (delta == 25'sd0);
      ofs_r  <= ofs_nxt;
      absv_r <= absv_nxt;
    end
  end

  // first multiply: sensitivity, floor of one, saturate where the clamp makes it moot
  logic [40:0] prod1;
  logic [32:0] scl_full;
  logic [16:0] scl_r;

  always_comb begin
    prod1 = 41'(mag_r) * 41'(sens_r);
    if (sens_r == ctm_pkg::SENS_UNITY) begin
      scl_full = 33'(mag_r);
    end else if (prod1[40:8] == 33'd0) begin
      scl_full = 33'd1;
    end else begin
      scl_full = prod1[40:8];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ctm_pkg::ST_MUL1) begin
      scl_r <= (scl_full > 33'(ctm_pkg::SCL_CAP)) ? ctm_pkg::SCL_CAP : scl_full[16:0];
    end
  end

  // second multiply: relative gain
  logic [32:0] prod2;
  logic [8:0]  step_r;

  assign prod2 = 33'(scl_r) * 33'(gain_r);

  always_ff @(posedge clk) begin
    if (state_r == ctm_pkg::ST_MUL2) begin
      step_r <= (prod2[32:8] > 25'(ctm_pkg::STEP_CAP)) ? ctm_pkg::STEP_CAP : prod2[16:8];
    end
  end

  // final stage: value, write-back and result
  logic [10:0]        lv11;
  logic [10:0]        relv;
  logic [6:0]         relc;
  logic [6:0]         newv;
  logic               emit;
  ctm_pkg::out_item_t res;
  ctm_pkg::ent_t      ent_w;

  always_comb begin
    lv11 = 11'(rd_ent.last_val);
    relv = neg_r ? (lv11 - 11'(step_r)) : (lv11 + 11'(step_r));
    if (relv[10]) begin
      relc = '0;
    end else if (relv > 11'd127) begin
      relc = ctm_pkg::MIDI_MAX;
    end else begin
      relc = relv[6:0];
    end
    newv = rd_ent.enc_rel ? relc : absv_r;

    ent_w  = rd_ent;
    tbl_wr = '0;
    emit   = 1'b0;
    res    = '0;

    case (item_r.opcode)
      ctm_pkg::OP_POS: begin
        if (flags.enc_v && !dz_r) begin
          tbl_wr.ent_we  = 1'b1;
          ent_w.last_pos = item_r.position;
          if (!flags.nav) begin
            if (!rd_ent.enc_rel) ent_w.fofs = ofs_r;
            if (newv != rd_ent.last_val) begin
              ent_w.last_val  = newv;
              emit            = 1'b1;
              res.msg_kind    = ctm_pkg::KIND_CC;
              res.out_channel = rd_ent.enc_ch;
              res.out_number  = rd_ent.enc_num;
              res.out_value   = newv;
            end
          end
        end
      end
      ctm_pkg::OP_BTN: begin
        if (flags.btn_v && !flags.nav) begin
          emit            = 1'b1;
          res.msg_kind    = ctm_pkg::KIND_NOTE;
          res.out_channel = rd_ent.btn_ch;
          res.out_number  = rd_ent.btn_num;
          res.out_value   = item_r.key_pressed ? ctm_pkg::MIDI_MAX : 7'd0;
        end
      end
      ctm_pkg::OP_WRMAP: begin
        tbl_wr.ent_we = 1'b1;
        if (item_r.slot_select) begin
          ent_w.btn_ch    = item_r.map_channel;
          ent_w.btn_num   = item_r.map_number;
          tbl_wr.btn_v_we = 1'b1;
          tbl_wr.btn_v    = 1'b1;
        end else begin
          ent_w.enc_ch    = item_r.map_channel;
          ent_w.enc_num   = item_r.map_number;
          ent_w.enc_rel   = item_r.map_relative;
          ent_w.last_pos  = '0;
          ent_w.last_val  = '0;
          ent_w.fofs      = '0;
          tbl_wr.enc_v_we = 1'b1;
          tbl_wr.enc_v    = 1'b1;
        end
      end
      ctm_pkg::OP_REMOVE: begin
        tbl_wr.enc_v_we = 1'b1;
        tbl_wr.btn_v_we = 1'b1;
      end
      ctm_pkg::OP_NAV: begin
        tbl_wr.nav_we = 1'b1;
        tbl_wr.nav    = item_r.nav_value;
      end
      default: ;
    endcase

    tbl_wr.ent = ent_w;
    // nothing happens unless the stage completes with an index in range
    if (!(fin_go && id_ok_r)) begin
      tbl_wr = '0;
      emit   = 1'b0;
    end
  end

  // output register
  ctm_pkg::out_item_t out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CTM_ASSERT_NEXT(a_accept_starts_read, accept, state_r == ctm_pkg::ST_READ,
                   "accepted transaction did not start a table read")
  `CTM_ASSERT_NOW(a_emit_needs_slot, emit, !out_valid_r || out_ready,
                  "result would overwrite a pending transaction")
  `CTM_ASSERT_NOW(a_note_velocity, out_valid_r && out_data_r.msg_kind == ctm_pkg::KIND_NOTE,
                  out_data_r.out_value == ctm_pkg::MIDI_MAX || out_data_r.out_value == 7'd0,
                  "note velocity is neither full nor zero")

endmodule
